### design/bsfn_pkg.sv
package bsfn_pkg;

    localparam int MAX_FLAGS  = 1024;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = MAX_FLAGS / WORD_BITS;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int MODE_W     = 3;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [MODE_W-1:0] MODE_SET     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLR_ALL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SET_ALL = 3'd5;

    localparam logic [0:0] REG_FLAG_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] FLAG_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_find;
        logic err;
        logic scan_done;
    } dp_status_t;

endpackage

### design/bsfn_dp.sv
module bsfn_dp import bsfn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [MODE_W-1:0]  mode,
    input  logic [IDX_W-1:0]   index,
    input  logic [CNT_W-1:0]   flag_count,
    output dp_status_t         status,
    output logic               flag_value,
    output logic               found,
    output logic [IDX_W-1:0]   found_index,
    output logic               error
);

    function automatic logic [BIT_W-1:0] trailing_zeros(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                n = BIT_W'(i);
        end
        return n;
    endfunction

    logic [WORD_BITS-1:0]  words_reg [NUM_WORDS];

    logic [MODE_W-1:0]     mode_reg;
    logic [IDX_W-1:0]      index_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  err_reg;
    logic [IDX_W:0]        start_reg;
    logic [WORD_IDX_W-1:0] ptr_reg;
    logic                  flag_value_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_index_reg;
    logic                  error_reg;

    logic [CNT_W-1:0]      eff_count;
    logic [IDX_W:0]        start_next;
    logic                  err_next;

    logic [IDX_W-1:0]      base;
    logic [WORD_BITS-1:0]  lo_mask;
    logic [WORD_BITS-1:0]  hi_mask;
    logic [WORD_BITS-1:0]  scan_word;
    logic                  scan_end;
    logic                  hit;
    logic                  last;

    logic [WORD_IDX_W-1:0] idx_word;
    logic [BIT_W-1:0]      idx_bit;

    assign eff_count  = (flag_count > CNT_W'(MAX_FLAGS)) ? CNT_W'(MAX_FLAGS) : flag_count;
    assign start_next = {1'b0, index} + (IDX_W+1)'(1);
    assign err_next   = (mode <= MODE_FIND) && ({1'b0, index} >= eff_count);

    assign idx_word = index_reg[IDX_W-1:BIT_W];
    assign idx_bit  = index_reg[BIT_W-1:0];

    // one word of the search per cycle, masked to [start, count)
    assign base      = {ptr_reg, BIT_W'(0)};
    assign scan_end  = start_reg[IDX_W] || ({1'b0, base} >= count_reg);
    assign lo_mask   = (ptr_reg == start_reg[IDX_W-1:BIT_W])
                     ? ({WORD_BITS{1'b1}} << start_reg[BIT_W-1:0]) : {WORD_BITS{1'b1}};
    assign hi_mask   = (count_reg[CNT_W-1:BIT_W] == {1'b0, ptr_reg})
                     ? ((WORD_BITS'(1) << count_reg[BIT_W-1:0]) - WORD_BITS'(1))
                     : {WORD_BITS{1'b1}};
    assign scan_word = words_reg[ptr_reg] & lo_mask & hi_mask;
    assign hit       = |scan_word;
    assign last      = (ptr_reg == WORD_IDX_W'(NUM_WORDS - 1));

    assign status.is_find   = (mode_reg == MODE_FIND);
    assign status.err       = err_reg;
    assign status.scan_done = scan_end || hit || last;

    assign flag_value  = flag_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign error       = error_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg        <= mode;
            index_reg       <= index;
            count_reg       <= eff_count;
            err_reg         <= err_next;
            start_reg       <= start_next;
            ptr_reg         <= start_next[IDX_W-1:BIT_W];
            flag_value_reg  <= 1'b0;
            found_reg       <= 1'b0;
            found_index_reg <= '0;
            error_reg       <= 1'b0;
        end
        else if (cmd.exec)
        begin
            if (err_reg)
                error_reg <= 1'b1;
            else if (mode_reg == MODE_TEST)
                flag_value_reg <= words_reg[idx_word][idx_bit];
        end
        else if (cmd.scan)
        begin
            if (!scan_end && hit)
            begin
                found_reg       <= 1'b1;
                found_index_reg <= {ptr_reg, trailing_zeros(scan_word)};
            end
            ptr_reg <= ptr_reg + WORD_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
                words_reg[w] <= '0;
        end
        else if (cmd.exec && !err_reg)
        begin
            unique case (mode_reg)
                MODE_SET:     words_reg[idx_word][idx_bit] <= 1'b1;
                MODE_CLEAR:   words_reg[idx_word][idx_bit] <= 1'b0;
                MODE_CLR_ALL:
                begin
                    for (int w = 0; w < NUM_WORDS; w++)
                        words_reg[w] <= '0;
                end
                MODE_SET_ALL:
                begin
                    for (int w = 0; w < NUM_WORDS; w++)
                        words_reg[w] <= '1;
                end
                default: ;
            endcase
        end
    end

endmodule

### design/bsfn_ctrl.sv
module bsfn_ctrl import bsfn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    assign busy = busy_reg;
    assign done = done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_find && !status.err)
                    state_next = S_SCAN;
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_RESP);
        end
    end

endmodule

### design/bitmap_set_find_next.sv
// channel  | direction | signals                                   | handshake
// ---------+-----------+-------------------------------------------+---------------------------
// command  | in        | mode, index                               | start & !busy
// result   | out       | flag_value, found, found_index, error     | done, one cycle, no stall
// config   | in/out    | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// One word at a time. Set, clear, test, clear all and set all go from accept through
// decode to the response; a find in range also scans k = 1..16 bitmap words before the
// response, one 64-bit word per cycle. done pulses in the last busy cycle.
// rst_n clears the bitmap to zero and flag_count to 1024 at once.
// Results cannot be stalled; busy stays high until the result word has gone out.
module bitmap_set_find_next import bsfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  index,
    output logic              done,
    output logic              flag_value,
    output logic              found,
    output logic [IDX_W-1:0]  found_index,
    output logic              error,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [CNT_W-1:0] flag_count_reg;
    logic             reg_sel;

    // register index is the word address
    assign reg_sel = (paddr[ADDR_W-1] == REG_FLAG_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? DATA_W'(flag_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_count_reg <= FLAG_COUNT_RESET;
        else if (psel && penable && pwrite && reg_sel)
            flag_count_reg <= pwdata[CNT_W-1:0];
    end

    bsfn_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bsfn_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .index       (index),
        .flag_count  (flag_count_reg),
        .status      (status),
        .flag_value  (flag_value),
        .found       (found),
        .found_index (found_index),
        .error       (error)
    );

`ifndef SYNTHESIS
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result word outside a busy period");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start a busy period");

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(error && (found || flag_value)))
        else $error("error result carries data");
`endif

endmodule

### tb/bitmap_set_find_next_tb.sv
module bitmap_set_find_next_tb;
    import bsfn_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_ROWS       = 33;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 170;

    localparam logic [ADDR_W-1:0] FLAG_COUNT_ADDR = ADDR_W'(4 * REG_FLAG_COUNT);
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR   = ADDR_W'(4);

    // modes the block must ignore
    localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

    typedef struct packed {
        logic             flag_value;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             error;
    } bsfn_result_t;

    typedef struct packed {
        logic              is_cfg;
        logic [MODE_W-1:0] m;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] cfg;
        logic              typed;
        bsfn_result_t      res;
    } step_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [MODE_W-1:0] mode = '0;
    logic [IDX_W-1:0]  index = '0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic              busy;
    logic              done;
    logic              flag_value;
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic              error;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // sideband that travels with start: use a typed expectation instead of the prediction
    logic              use_typed = 1'b0;
    bsfn_result_t      typed_exp = '0;

    logic [WORD_BITS-1:0] shadow_words [NUM_WORDS];
    logic [CNT_W-1:0]     shadow_count;
    bsfn_result_t         pending_results [$];
    int                   fail_count = 0;
    int                   quiet_cycles = 0;
    step_row_t            plan [NUM_ROWS];

    bitmap_set_find_next DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .index       (index),
        .done        (done),
        .flag_value  (flag_value),
        .found       (found),
        .found_index (found_index),
        .error       (error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bsfn_result_t outcome(input logic fv, input logic fd,
                                             input int unsigned fi, input logic er);
        bsfn_result_t r;
        r.flag_value  = fv;
        r.found       = fd;
        r.found_index = IDX_W'(fi);
        r.error       = er;
        return r;
    endfunction

    function automatic step_row_t cmd(input logic [MODE_W-1:0] m, input int unsigned idx);
        step_row_t s;
        s = '0;
        s.m = m;
        s.idx = IDX_W'(idx);
        return s;
    endfunction

    function automatic step_row_t cmdx(input logic [MODE_W-1:0] m, input int unsigned idx,
                                       input bsfn_result_t res);
        step_row_t s;
        s = cmd(m, idx);
        s.typed = 1'b1;
        s.res = res;
        return s;
    endfunction

    function automatic step_row_t cfgw(input logic [DATA_W-1:0] value);
        step_row_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.cfg = value;
        return s;
    endfunction

    // updates the shadow bitmap and returns the result word of one command
    function automatic bsfn_result_t apply_command(input logic [MODE_W-1:0] m,
                                                   input logic [IDX_W-1:0] idx);
        bsfn_result_t r;
        int unsigned  limit;
        int unsigned  w;
        int unsigned  b;
        r = '0;
        limit = (shadow_count > MAX_FLAGS) ? MAX_FLAGS : shadow_count;
        w = idx / WORD_BITS;
        b = idx % WORD_BITS;
        if (m <= MODE_FIND && idx >= limit)
            r.error = 1'b1;
        else
        begin
            case (m)
                MODE_SET:   shadow_words[w][b] = 1'b1;
                MODE_CLEAR: shadow_words[w][b] = 1'b0;
                MODE_TEST:  r.flag_value = shadow_words[w][b];
                MODE_FIND:
                begin
                    for (int p = idx + 1; p < limit && !r.found; p++)
                    begin
                        if (shadow_words[p / WORD_BITS][p % WORD_BITS])
                        begin
                            r.found = 1'b1;
                            r.found_index = IDX_W'(p);
                        end
                    end
                end
                MODE_CLR_ALL:
                    for (int i = 0; i < NUM_WORDS; i++)
                        shadow_words[i] = '0;
                MODE_SET_ALL:
                    for (int i = 0; i < NUM_WORDS; i++)
                        shadow_words[i] = '1;
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        bsfn_result_t pred;
        bsfn_result_t want;
        logic         progress;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
                shadow_words[i] = '0;
            shadow_count = FLAG_COUNT_RESET;
            pending_results.delete();
            quiet_cycles = 0;
        end
        else
        begin
            progress = 1'b0;
            if (psel && penable && pready)
            begin
                progress = 1'b1;
                if (pwrite && paddr == FLAG_COUNT_ADDR)
                    shadow_count = pwdata[CNT_W-1:0];
            end
            if (start && !busy)
            begin
                progress = 1'b1;
                pred = apply_command(mode, index);
                pending_results.push_back(use_typed ? typed_exp : pred);
            end
            if (done)
            begin
                progress = 1'b1;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with nothing expected", $time);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("flag_value", want.flag_value, flag_value);
                    compare_field("found", want.found, found);
                    compare_field("found_index", want.found_index, found_index);
                    compare_field("error", want.error, error);
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                             input logic typed, input bsfn_result_t res, input int idle_pct);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        index <= idx;
        use_typed <= typed;
        typed_exp <= res;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending until every pending result word has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // write, then read flag_count back and compare with the shadow copy
    task automatic set_flag_count(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= FLAG_COUNT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        compare_field("prdata", {{(DATA_W-CNT_W){1'b0}}, shadow_count}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        bsfn_result_t      none;
        bsfn_result_t      oob;
        int unsigned       phase_counts [NUM_PHASES];
        int unsigned       cnt;
        int unsigned       lim;
        int unsigned       w;
        int                idle;
        int                n;
        int unsigned       r;
        int unsigned       k;
        logic [MODE_W-1:0] m;
        int unsigned       idx;

        none = outcome(0, 0, 0, 0);
        oob  = outcome(0, 0, 0, 1);
        plan = '{
            cmdx(MODE_TEST, 0, none),
            cmdx(MODE_FIND, 0, none),
            cmdx(MODE_SET, 1023, none),
            cmdx(MODE_FIND, 0, outcome(0, 1, 1023, 0)),
            cmdx(MODE_TEST, 1023, outcome(1, 0, 0, 0)),
            cmd(MODE_SET, 0),
            cmd(MODE_SET, 63),
            cmd(MODE_SET, 64),
            cmd(MODE_FIND, 0),
            cmd(MODE_FIND, 63),
            cmd(MODE_CLEAR, 63),
            cmd(MODE_FIND, 0),
            cmdx(MODE_BAD_LO, 5, none),
            cmdx(MODE_BAD_HI, 1023, none),
            cmdx(MODE_SET_ALL, 777, none),
            cmdx(MODE_TEST, 512, outcome(1, 0, 0, 0)),
            cmdx(MODE_CLR_ALL, 1023, none),
            cmdx(MODE_FIND, 0, none),
            cfgw(1),
            cmdx(MODE_SET, 0, none),
            cmdx(MODE_SET, 1, oob),
            cmdx(MODE_FIND, 0, none),
            cmdx(MODE_TEST, 0, outcome(1, 0, 0, 0)),
            cfgw(0),
            cmdx(MODE_TEST, 0, oob),
            cmdx(MODE_SET_ALL, 0, none),
            cfgw(32'hFFFF_FFFF),
            cmdx(MODE_FIND, 1022, outcome(0, 1, 1023, 0)),
            cfgw(65),
            cmd(MODE_CLEAR, 64),
            cmd(MODE_FIND, 62),
            cmdx(MODE_TEST, 65, oob),
            cfgw(1024)
        };
        phase_counts = '{1024, 2047, 64, 1, 1000, 0, 65, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                set_flag_count(FLAG_COUNT_ADDR, plan[i].cfg);
            end
            else
                send_item(plan[i].m, plan[i].idx, plan[i].typed, plan[i].res, 0);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == 0)
                set_flag_count(UNMAPPED_ADDR, $urandom());
            // phase 5 picks a random count; phase 7 runs with count zero
            cnt = (p == 5) ? $urandom_range(1024, 1) : phase_counts[p];
            set_flag_count(FLAG_COUNT_ADDR, ($urandom() & ~32'h7ff) | cnt);
            lim = (cnt > MAX_FLAGS) ? MAX_FLAGS : cnt;
            case (p % 4)
                1:       idle = 62;
                3:       idle = 33;
                default: idle = 0;
            endcase
            n = (cnt == 0) ? 40 : PHASE_ITEMS;
            for (int j = 0; j < n; j++)
            begin
                r = $urandom_range(99);
                if (r < 28)
                    m = MODE_SET;
                else if (r < 40)
                    m = MODE_CLEAR;
                else if (r < 58)
                    m = MODE_TEST;
                else if (r < 82)
                    m = MODE_FIND;
                else if (r < 86)
                    m = MODE_CLR_ALL;
                else if (r < 89)
                    m = MODE_SET_ALL;
                else if (r < 92)
                    m = $urandom_range(1) ? MODE_BAD_HI : MODE_BAD_LO;
                else
                    m = MODE_W'($urandom_range(7));
                k = $urandom_range(9);
                if (lim == 0 || k == 0)
                    idx = $urandom_range(1023);
                else if (k < 3)
                begin
                    // word edges, where the scan crosses into the next word
                    w = $urandom_range((lim - 1) / WORD_BITS);
                    idx = w * WORD_BITS + ($urandom_range(1) ? WORD_BITS - 1 : 0);
                    if (idx >= lim)
                        idx = lim - 1;
                end
                else
                    idx = $urandom_range(lim - 1);
                send_item(m, IDX_W'(idx), 1'b0, none, idle);
                if (p == 2 && $urandom_range(99) < 3)
                    drain();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
